FILE: rtl/sfb_pkg.sv
// Shared constants for the scope framebuffer plot and scan-out block.
// Holds opcodes, display bus command codes and register indexes.
// No dependencies.
`default_nettype none

package sfb_pkg;

    // item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_PLOT  = 2'd1;
    localparam logic [1:0] OP_SCAN  = 2'd2;

    // display bus words
    localparam logic [7:0] PAGE_CMD   = 8'hB8;
    localparam logic [7:0] COLUMN_CMD = 8'h40;
    localparam logic [7:0] TOP_BIT    = 8'h80;

    localparam logic [1:0] CS_BOTH  = 2'd0;
    localparam logic [1:0] CS_LEFT  = 2'd1;
    localparam logic [1:0] CS_RIGHT = 2'd2;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // configuration register indexes (paddr[2])
    localparam logic REG_PLOT_COLUMNS = 1'b0;
    localparam logic REG_PLOT_BASE    = 1'b1;

    localparam logic [7:0] PLOT_COLUMNS_RESET = 8'd100;
    localparam logic [9:0] PLOT_BASE_RESET    = 10'd996;

endpackage

`default_nettype wire

FILE: rtl/sfb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/scope_framebuffer_plot_and_scanout.sv
// Top level of the scope framebuffer: plot, background write and scan-out.
// Depends on sfb_pkg and sfb_ram.
`default_nettype none

// The frame store is one synchronous RAM of FRAME_BYTES bytes with a
// registered read; its contents are undefined until written, so there is
// no clearing pass after reset and background writes must load every byte
// before it is plotted into or scanned out. A plot reads the byte, ORs in
// the pixel and writes it back. A scan step reads the byte and sends a data
// word; at a row change it sends a page command and a column command before
// the data word. The bus side may stall the single output register at any
// word. The input is taken again once the last word of a step has moved
// into the output register.
module scope_framebuffer_plot_and_scanout #(
    parameter int FRAME_BYTES = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [9:0]  byte_address,
    input  wire logic [7:0]  byte_value,
    input  wire logic [6:0]  sample_column,
    input  wire logic [7:0]  sample_level,
    // result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       chip_select,
    output logic             register_select,
    output logic [7:0]       bus_byte,
    output logic             last_word
);

    import sfb_pkg::*;

    localparam int AW        = $clog2(FRAME_BYTES);
    localparam int MW        = (AW > 10) ? AW + 1 : 11;
    localparam int MOD_STEPS = 1023 / FRAME_BYTES;
    localparam logic [MW-1:0] FB_M      = MW'(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLOT_WB,
        S_PAGE,
        S_COLUMN,
        S_DATA
    } state_t;

    // reduce a value below 1024 modulo the frame size
    function automatic logic [MW-1:0] wrap_fb(input logic [MW-1:0] x);
        logic [MW-1:0] r;
        r = x;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            if (r >= FB_M)
            begin
                r = r - FB_M;
            end
        end
        return r;
    endfunction

    state_t        state_reg, state_next;
    logic [7:0]    plot_columns_reg, plot_columns_next;
    logic [9:0]    plot_base_reg, plot_base_next;
    logic [AW-1:0] scan_pointer_reg, scan_pointer_next;
    logic [7:0]    column_count_reg, column_count_next;
    logic [2:0]    page_number_reg, page_number_next;
    logic [AW-1:0] plot_addr_reg, plot_addr_next;
    logic [7:0]    plot_mask_reg, plot_mask_next;
    logic [1:0]    data_cs_reg, data_cs_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    chip_select_reg, chip_select_next;
    logic          register_select_reg, register_select_next;
    logic [7:0]    bus_byte_reg, bus_byte_next;
    logic          last_word_reg, last_word_next;

    logic          accept;
    logic          cfg_write;
    logic          out_free;
    logic          plot_ok;
    logic [MW-1:0] base_m;
    logic [MW-1:0] sub_m;
    logic [MW-1:0] plot_diff;
    logic [MW-1:0] write_m;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    sfb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || out_ready;
    assign pready    = 1'b1;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign chip_select     = chip_select_reg;
    assign register_select = register_select_reg;
    assign bus_byte        = bus_byte_reg;
    assign last_word       = last_word_reg;

    always_comb
    begin
        unique case (paddr[2])
            REG_PLOT_COLUMNS: prdata = {24'd0, plot_columns_reg};
            REG_PLOT_BASE:    prdata = {22'd0, plot_base_reg};
        endcase
    end

    // plot address: base - column - 128 * (level / 8), modulo the frame size
    assign plot_ok   = (sample_level[7:6] == 2'b00)
                       && ({1'b0, sample_column} < plot_columns_reg);
    assign base_m    = wrap_fb(MW'(plot_base_reg));
    assign sub_m     = wrap_fb(MW'({sample_level[5:3], sample_column}));
    assign write_m   = wrap_fb(MW'(byte_address));

    always_comb
    begin
        plot_diff = base_m + (FB_M - sub_m);
        if (plot_diff >= FB_M)
        begin
            plot_diff = plot_diff - FB_M;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = write_m[AW-1:0];
        ram_wdata = byte_value;
        ram_re    = 1'b0;
        ram_raddr = scan_pointer_reg;
        if (state_reg == S_PLOT_WB)
        begin
            ram_we    = 1'b1;
            ram_waddr = plot_addr_reg;
            ram_wdata = ram_rdata | plot_mask_reg;
        end
        else if (accept)
        begin
            case (opcode)
                OP_WRITE:
                begin
                    ram_we = 1'b1;
                end
                OP_PLOT:
                begin
                    ram_re    = plot_ok;
                    ram_raddr = plot_diff[AW-1:0];
                end
                OP_SCAN:
                begin
                    ram_re = 1'b1;
                end
                default:
                begin
                    ram_re = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        plot_columns_next    = plot_columns_reg;
        plot_base_next       = plot_base_reg;
        scan_pointer_next    = scan_pointer_reg;
        column_count_next    = column_count_reg;
        page_number_next     = page_number_reg;
        plot_addr_next       = plot_addr_reg;
        plot_mask_next       = plot_mask_reg;
        data_cs_next         = data_cs_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        chip_select_next     = chip_select_reg;
        register_select_next = register_select_reg;
        bus_byte_next        = bus_byte_reg;
        last_word_next       = last_word_reg;

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_PLOT_COLUMNS: plot_columns_next = pwdata[7:0];
                REG_PLOT_BASE:    plot_base_next    = pwdata[9:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && opcode == OP_PLOT && plot_ok)
                begin
                    plot_addr_next = plot_diff[AW-1:0];
                    plot_mask_next = TOP_BIT >> sample_level[2:0];
                    state_next     = S_PLOT_WB;
                end
                else if (accept && opcode == OP_SCAN)
                begin
                    scan_pointer_next = (scan_pointer_reg == LAST_ADDR)
                                        ? '0 : scan_pointer_reg + 1'b1;
                    if (column_count_reg[7])
                    begin
                        // row done: restart columns, advance page
                        column_count_next = 8'd1;
                        page_number_next  = page_number_reg + 1'b1;
                        data_cs_next      = CS_LEFT;
                        state_next        = S_PAGE;
                    end
                    else
                    begin
                        column_count_next = column_count_reg + 1'b1;
                        data_cs_next      = column_count_reg[6] ? CS_RIGHT : CS_LEFT;
                        state_next        = S_DATA;
                    end
                end
            end
            S_PLOT_WB:
            begin
                state_next = S_IDLE;
            end
            S_PAGE:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    chip_select_next     = CS_BOTH;
                    register_select_next = RS_COMMAND;
                    bus_byte_next        = PAGE_CMD | {5'd0, page_number_reg};
                    last_word_next       = 1'b0;
                    state_next           = S_COLUMN;
                end
            end
            S_COLUMN:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    chip_select_next     = CS_BOTH;
                    register_select_next = RS_COMMAND;
                    bus_byte_next        = COLUMN_CMD;
                    last_word_next       = 1'b0;
                    state_next           = S_DATA;
                end
            end
            S_DATA:
            begin
                // read data holds: no new read until back in idle
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    chip_select_next     = data_cs_reg;
                    register_select_next = RS_DATA;
                    bus_byte_next        = ram_rdata;
                    last_word_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            plot_columns_reg    <= PLOT_COLUMNS_RESET;
            plot_base_reg       <= PLOT_BASE_RESET;
            scan_pointer_reg    <= '0;
            column_count_reg    <= '0;
            page_number_reg     <= '0;
            plot_addr_reg       <= '0;
            plot_mask_reg       <= '0;
            data_cs_reg         <= CS_LEFT;
            out_valid_reg       <= 1'b0;
            chip_select_reg     <= CS_BOTH;
            register_select_reg <= RS_COMMAND;
            bus_byte_reg        <= '0;
            last_word_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            plot_columns_reg    <= plot_columns_next;
            plot_base_reg       <= plot_base_next;
            scan_pointer_reg    <= scan_pointer_next;
            column_count_reg    <= column_count_next;
            page_number_reg     <= page_number_next;
            plot_addr_reg       <= plot_addr_next;
            plot_mask_reg       <= plot_mask_next;
            data_cs_reg         <= data_cs_next;
            out_valid_reg       <= out_valid_next;
            chip_select_reg     <= chip_select_next;
            register_select_reg <= register_select_next;
            bus_byte_reg        <= bus_byte_next;
            last_word_reg       <= last_word_next;
        end
    end

`ifndef SYNTH
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_count_reg <= 8'd128)
        else $error("column count beyond a full row");

    a_no_read_on_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLOT_WB) |-> (ram_we && !ram_re))
        else $error("frame read overlaps plot write-back");

    a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_SCAN) |=> !in_ready)
        else $error("input taken while a scan step is in flight");

    a_command_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && register_select == RS_COMMAND) |-> (!last_word && chip_select == CS_BOTH))
        else $error("command word marked last or sent to one chip");
`endif

endmodule

`default_nettype wire

FILE: bench/scope_framebuffer_plot_and_scanout_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for scope_framebuffer_plot_and_scanout: walks a directed table,
// runs a stretch with no idling, then randomised register phases.
// Depends on sfb_pkg and the block's RTL.
module scope_framebuffer_plot_and_scanout_tb;
    import sfb_pkg::*;

    localparam int FRAME_BYTES = 1024;
    localparam int ROW_COLUMNS = 128;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT = 17;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int STRETCH_ITEMS = 40;
    localparam int PHASE_ITEMS = 20;
    localparam int NUM_PHASES = 6;
    localparam int RANDOM_PHASE = 3;
    localparam logic [7:0] PHASE_COLUMNS [NUM_PHASES] =
        '{8'd128, 8'd0, 8'd1, 8'd0, 8'd128, 8'd100};
    localparam logic [9:0] PHASE_BASE [NUM_PHASES] =
        '{10'd0, 10'd1023, 10'd512, 10'd0, 10'd1023, 10'd996};

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] addr;
        logic [7:0] value;
        logic [6:0] col;
        logic [7:0] level;
    } sfb_item_t;

    typedef struct packed {
        logic [1:0] chip_sel;
        logic       reg_sel;
        logic [7:0] data;
        logic       last;
    } bus_word_t;

    typedef struct packed {
        sfb_item_t item;
        logic      typed;
        bus_word_t want;
    } dir_row_t;

    localparam bus_word_t NO_WORD = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [9:0]  byte_address;
    logic [7:0]  byte_value;
    logic [6:0]  sample_column;
    logic [7:0]  sample_level;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  chip_select;
    logic        register_select;
    logic [7:0]  bus_byte;
    logic        last_word;

    // high: neither side idles
    logic        calm_bus = 1'b0;

    // shadow of the block
    logic [7:0]  frame_shadow [FRAME_BYTES];
    bit          frame_known [FRAME_BYTES];
    logic [9:0]  scan_ptr;
    logic [7:0]  col_count;
    logic [2:0]  page_num;
    logic [7:0]  cfg_columns;
    logic [9:0]  cfg_base;

    bus_word_t   bus_words_due[$];
    bus_word_t   fresh_words [3];
    int          n_fail = 0;
    int          quiet_cycles = 0;

    scope_framebuffer_plot_and_scanout dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= calm_bus ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Update the shadow frame for one item; return how many bus words it yields.
    function automatic int advance_frame_model(input sfb_item_t it);
        int n;
        logic [9:0] target;
        n = 0;
        case (it.op)
            OP_WRITE: begin
                frame_shadow[it.addr] = it.value;
                frame_known[it.addr]  = 1'b1;
            end
            OP_PLOT: begin
                if (it.level < 8'd64 && {1'b0, it.col} < cfg_columns) begin
                    target = cfg_base - {3'd0, it.col} - {it.level[5:3], 7'd0};
                    frame_shadow[target] = frame_shadow[target] | (TOP_BIT >> it.level[2:0]);
                end
            end
            OP_SCAN: begin
                if (col_count == 8'(ROW_COLUMNS)) begin
                    col_count = 8'd0;
                    page_num = page_num + 3'd1;
                    fresh_words[n] = '{CS_BOTH, RS_COMMAND, PAGE_CMD | {5'd0, page_num}, 1'b0};
                    n++;
                    fresh_words[n] = '{CS_BOTH, RS_COMMAND, COLUMN_CMD, 1'b0};
                    n++;
                end
                fresh_words[n] = '{(col_count <= 8'd63) ? CS_LEFT : CS_RIGHT, RS_DATA,
                                   frame_shadow[scan_ptr], 1'b1};
                n++;
                col_count = col_count + 8'd1;
                scan_ptr = scan_ptr + 10'd1;
            end
            default: ;
        endcase
        return n;
    endfunction

    // Turn a read of a never-written byte into a write of that byte.
    function automatic sfb_item_t keep_known(input sfb_item_t it);
        sfb_item_t fixed;
        logic [9:0] target;
        fixed  = it;
        target = cfg_base - {3'd0, it.col} - {it.level[5:3], 7'd0};
        if (it.op == OP_SCAN && !frame_known[scan_ptr]) begin
            fixed.op   = OP_WRITE;
            fixed.addr = scan_ptr;
        end
        if (it.op == OP_PLOT && it.level < 8'd64 && {1'b0, it.col} < cfg_columns
            && !frame_known[target]) begin
            fixed.op   = OP_WRITE;
            fixed.addr = target;
        end
        return fixed;
    endfunction

    function automatic sfb_item_t rand_item();
        sfb_item_t it;
        int pick;
        pick = $urandom_range(99);
        it.op    = (pick < 45) ? OP_SCAN : (pick < 80) ? OP_PLOT :
                   (pick < 93) ? OP_WRITE : OP_UNUSED;
        it.addr  = 10'($urandom_range(FRAME_BYTES - 1));
        it.value = 8'($urandom_range(255));
        it.col   = 7'($urandom_range(127));
        it.level = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(63));
        // keep most plots inside the plot width
        if (cfg_columns != 8'd0 && $urandom_range(1) == 1)
            it.col = 7'($urandom_range(int'(cfg_columns) - 1));
        return keep_known(it);
    endfunction

    function automatic bus_word_t left_data(input logic [7:0] data);
        return '{CS_LEFT, RS_DATA, data, 1'b1};
    endfunction

    function automatic dir_row_t make_row(input logic [1:0] op, input logic [9:0] addr,
                                          input logic [7:0] value, input logic [6:0] col,
                                          input logic [7:0] level, input logic typed,
                                          input bus_word_t want);
        dir_row_t row;
        row.item  = '{op, addr, value, col, level};
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    task automatic send_item(input sfb_item_t it, input logic typed, input bus_word_t want);
        int n;
        while (!calm_bus && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= it.op;
        byte_address  <= it.addr;
        byte_value    <= it.value;
        sample_column <= it.col;
        sample_level  <= it.level;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n = advance_frame_model(it);
        if (typed)
            bus_words_due.push_back(want);
        else
            for (int k = 0; k < n; k++) bus_words_due.push_back(fresh_words[k]);
    endtask

    // Hold the sender until every expected bus word has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bus_words_due.size() != 0) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_check(input logic idx, input logic [31:0] want, input int width,
                             input string name);
        logic [31:0] mask;
        mask    = (32'd1 << width) - 32'd1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if ((prdata & mask) != want) begin
            $error("%s: expected %0d, got %0d", name, want, prdata & mask);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_plot_window(input logic [7:0] columns, input logic [9:0] base);
        reg_write(REG_PLOT_COLUMNS, {24'd0, columns});
        reg_write(REG_PLOT_BASE, {22'd0, base});
        cfg_columns = columns;
        cfg_base    = base;
        reg_check(REG_PLOT_COLUMNS, {24'd0, columns}, 8, "plot_columns");
        reg_check(REG_PLOT_BASE, {22'd0, base}, 10, "plot_base");
    endtask

    always @(posedge clk) begin
        bus_word_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (bus_words_due.size() == 0) begin
                    $error("bus word with none expected: cs %0d rs %0d byte %02h last %0d",
                           chip_select, register_select, bus_byte, last_word);
                    n_fail++;
                end else begin
                    want = bus_words_due.pop_front();
                    if (chip_select !== want.chip_sel) begin
                        $error("chip_select: expected %0d, got %0d", want.chip_sel, chip_select);
                        n_fail++;
                    end
                    if (register_select !== want.reg_sel) begin
                        $error("register_select: expected %0d, got %0d",
                               want.reg_sel, register_select);
                        n_fail++;
                    end
                    if (bus_byte !== want.data) begin
                        $error("bus_byte: expected %02h, got %02h", want.data, bus_byte);
                        n_fail++;
                    end
                    if (last_word !== want.last) begin
                        $error("last_word: expected %0d, got %0d", want.last, last_word);
                        n_fail++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no item moved for %0d cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t  plan[$];

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        opcode        = OP_WRITE;
        byte_address  = '0;
        byte_value    = '0;
        sample_column = '0;
        sample_level  = '0;
        scan_ptr      = '0;
        col_count     = '0;
        page_num      = '0;
        cfg_columns   = PLOT_COLUMNS_RESET;
        cfg_base      = PLOT_BASE_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_check(REG_PLOT_COLUMNS, {24'd0, PLOT_COLUMNS_RESET}, 8, "plot_columns");
        reg_check(REG_PLOT_BASE, {22'd0, PLOT_BASE_RESET}, 10, "plot_base");

        // every byte that a row reads is written by an earlier row
        // first row after reset: plain data words, no page command
        plan.push_back(make_row(OP_WRITE, 10'd0, 8'h00, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_WRITE, 10'd1, 8'hFF, 7'd127, 8'd255, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_SCAN, 10'd0, 8'h00, 7'd0, 8'd0, 1'b1, left_data(8'h00)));
        plan.push_back(make_row(OP_SCAN, 10'd1023, 8'hFF, 7'd127, 8'd255, 1'b1,
                                left_data(8'hFF)));
        plan.push_back(make_row(OP_WRITE, 10'd1023, 8'h5A, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_WRITE, 10'd996, 8'h00, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_WRITE, 10'd100, 8'h3C, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd0, 8'd7, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd99, 8'd63, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd0, 8'd56, 1'b0, NO_WORD));
        // column at or past the plot width, level past the top: all dropped
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd100, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd127, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd5, 8'd64, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_PLOT, 10'd0, 8'h00, 7'd5, 8'd255, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_UNUSED, 10'd1023, 8'hFF, 7'd127, 8'd255, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_WRITE, 10'd2, 8'h80, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_SCAN, 10'd0, 8'h00, 7'd0, 8'd0, 1'b1, left_data(8'h80)));
        plan.push_back(make_row(OP_WRITE, 10'd3, 8'hC3, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_SCAN, 10'd0, 8'h00, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_UNUSED, 10'd0, 8'h00, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_WRITE, 10'd4, 8'h24, 7'd0, 8'd0, 1'b0, NO_WORD));
        plan.push_back(make_row(OP_SCAN, 10'd0, 8'h00, 7'd0, 8'd0, 1'b0, NO_WORD));

        foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);
        drain_results();

        // a stretch with no idling on either side
        calm_bus <= 1'b1;
        for (int s = 0; s < STRETCH_ITEMS; s++)
            send_item(rand_item(), 1'b0, NO_WORD);
        calm_bus <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            // a plot may still be writing back after the last word came out
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (p == RANDOM_PHASE)
                set_plot_window(8'($urandom_range(ROW_COLUMNS)),
                                10'($urandom_range(FRAME_BYTES - 1)));
            else
                set_plot_window(PHASE_COLUMNS[p], PHASE_BASE[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(39) == 0) drain_results();
                send_item(rand_item(), 1'b0, NO_WORD);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bus_words_due.size() != 0) begin
            $error("%0d bus words never arrived", bus_words_due.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/sfb_pkg.sv
rtl/sfb_ram.sv
rtl/scope_framebuffer_plot_and_scanout.sv
bench/scope_framebuffer_plot_and_scanout_tb.sv
